// File: hw/rtl/tlb_fifo_lfu_replacement_assert.svh
// Assertion macros for the TLB replacement block.
// Each macro expands to one labeled concurrent assertion on a clock and an
// active-low reset.
`ifndef TLB_FIFO_LFU_REPLACEMENT_ASSERT_SVH
`define TLB_FIFO_LFU_REPLACEMENT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLBFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("TLB replacement check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("TLB replacement check failed");

`endif

// File: hw/rtl/tlbfl_pkg.sv
// -----------------------------------------------------------------------------
// TLB replacement package
// Shared field widths, codes, transaction types and control interface types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlbfl_pkg;

    localparam int PAGE_W  = 20;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;

    // Opcode and policy codes.
    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_FILL    = 1'b1;
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LFU  = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic              opcode;
        logic [PAGE_W-1:0] virtual_page;
        logic [PAGE_W-1:0] fill_frame;
        logic              fill_frame_valid;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic               hit;
        logic [PAGE_W-1:0]  frame;
        logic               frame_valid;
        logic [TOTAL_W-1:0] hits_so_far;
        logic [TOTAL_W-1:0] misses_so_far;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic fill_fifo;
        logic fill_lfu;
        logic scan_init;
        logic scan_step;
        logic evict;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_fill;
        logic lfu;
        logic any_match;
        logic any_free;
        logic scan_last;
    } ctl_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlb_fifo_lfu_replacement.sv
// -----------------------------------------------------------------------------
// Fully associative TLB with FIFO or LFU replacement
// Lookup and fill of page translations with running hit and miss totals.
// -----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Lookups, FIFO
// fills and LFU fills that hit a present page or find a free entry capture
// the transaction, then do the parallel tag compare and entry update. An LFU
// fill into a full table adds a victim scan: a single comparator walks the
// use counts one entry per cycle to pick the victim. Every transaction yields
// exactly one result, shown on result for one cycle with result_valid high in
// the cycle after the work finishes; the receiver cannot stall, so it must
// take the result in that cycle. A new transaction may be started in the same
// cycle the result is shown. The user must write the policy register with
// cfg_we and cfg_wdata only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_lfu_replacement
    import tlbfl_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_item_t item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    output logic          result_valid,
    output out_item_t     result
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Sequencer.
    tlbfl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Entry storage and result path.
    tlbfl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tlbfl_ctrl.sv
// -----------------------------------------------------------------------------
// TLB replacement controller
// Sequences accept, tag compare, optional victim scan and result issue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbfl_ctrl
    import tlbfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire ctl_status_t status,
    output ctl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   finish;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (!status.is_fill)
                begin
                    cmd.lookup = 1'b1;
                    finish     = 1'b1;
                end
                else if (!status.lfu)
                begin
                    cmd.fill_fifo = 1'b1;
                    finish        = 1'b1;
                end
                else if (status.any_match || status.any_free)
                begin
                    cmd.fill_lfu = 1'b1;
                    finish       = 1'b1;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    cmd.evict = 1'b1;
                    finish    = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (finish)
        begin
            state_next = S_IDLE;
        end
        cmd.emit  = finish;
        busy_next = (state_next != S_IDLE);
    end

    // State and registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tlbfl_dp.sv
// -----------------------------------------------------------------------------
// TLB replacement datapath
// Entry storage, parallel tag compare, use-count scan and result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbfl_dp
    import tlbfl_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire ctl_cmd_t cmd,
    output ctl_status_t   status,
    output logic          result_valid,
    output out_item_t     result
);

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_ONE
    } cnt_mode_t;

    logic                 policy_reg;
    in_item_t             item_reg;
    logic                 used_reg  [ENTRIES];
    logic [PAGE_W-1:0]    page_reg  [ENTRIES];
    logic [PAGE_W-1:0]    frame_reg [ENTRIES];
    logic                 ok_reg    [ENTRIES];
    logic [COUNT_W-1:0]   count_reg [ENTRIES];
    logic [IDX_W-1:0]     next_slot_reg;
    logic [IDX_W-1:0]     next_slot_next;
    logic [TOTAL_W-1:0]   hit_total_reg;
    logic [TOTAL_W-1:0]   miss_total_reg;
    logic [TOTAL_W-1:0]   hit_total_next;
    logic [TOTAL_W-1:0]   miss_total_next;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [COUNT_W-1:0]   best_cnt_reg;
    out_item_t            out_reg;
    out_item_t            out_next;
    logic                 out_valid_reg;

    logic [ENTRIES-1:0]   match_vec;
    logic [ENTRIES-1:0]   free_vec;
    logic [IDX_W-1:0]     match_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [COUNT_W-1:0]   scan_cnt;
    logic                 scan_less;
    logic [IDX_W-1:0]     victim_idx;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    cnt_mode_t            cnt_mode;
    logic [COUNT_W-1:0]   cnt_old;
    logic [COUNT_W-1:0]   cnt_wr;
    logic [PAGE_W-1:0]    wr_frame;

    // Lowest set bit of a vector, zero when none is set.
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
        end
        else if (cfg_we)
        begin
            policy_reg <= cfg_wdata;
        end
    end

    // Captured transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    // Parallel tag compare and free-slot detect.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = used_reg[i] && (page_reg[i] == item_reg.virtual_page);
            free_vec[i]  = !used_reg[i];
        end
    end

    assign match_idx = first_set(match_vec);
    assign free_idx  = first_set(free_vec);

    // One use count is compared per scan cycle against the best so far.
    assign scan_cnt   = count_reg[scan_idx_reg];
    assign scan_less  = (scan_cnt < best_cnt_reg);
    assign victim_idx = scan_less ? scan_idx_reg : best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_idx_reg <= IDX_W'(1);
            best_idx_reg <= '0;
            best_cnt_reg <= count_reg[0];
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            best_idx_reg <= victim_idx;
            if (scan_less)
            begin
                best_cnt_reg <= scan_cnt;
            end
        end
    end

    assign status.is_fill   = (item_reg.opcode == OP_FILL);
    assign status.lfu       = (policy_reg == POLICY_LFU);
    assign status.any_match = |match_vec;
    assign status.any_free  = |free_vec;
    assign status.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));

    // Entry write select.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = next_slot_reg;
        cnt_mode = CNT_KEEP;
        if (cmd.fill_fifo)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.fill_lfu)
        begin
            wr_en = 1'b1;
            if (status.any_match)
            begin
                wr_idx   = match_idx;
                cnt_mode = CNT_INC;
            end
            else
            begin
                wr_idx   = free_idx;
                cnt_mode = CNT_ONE;
            end
        end
        else if (cmd.evict)
        begin
            wr_en    = 1'b1;
            wr_idx   = victim_idx;
            cnt_mode = CNT_ONE;
        end
    end

    assign cnt_old  = count_reg[wr_idx];
    assign wr_frame = item_reg.fill_frame_valid ? item_reg.fill_frame : '0;

    always_comb
    begin
        case (cnt_mode)
            CNT_INC:
            begin
                cnt_wr = (cnt_old == {COUNT_W{1'b1}}) ? cnt_old : cnt_old + COUNT_W'(1);
            end
            CNT_ONE:
            begin
                cnt_wr = COUNT_W'(1);
            end
            default:
            begin
                cnt_wr = cnt_old;
            end
        endcase
    end

    // Entry control state: used marks and use counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                used_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            used_reg[wr_idx]  <= 1'b1;
            count_reg[wr_idx] <= cnt_wr;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_reg[wr_idx]  <= item_reg.virtual_page;
            frame_reg[wr_idx] <= wr_frame;
            ok_reg[wr_idx]    <= item_reg.fill_frame_valid;
        end
    end

    // Rotating fill pointer and hit/miss totals.
    always_comb
    begin
        next_slot_next  = next_slot_reg;
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        if (cmd.fill_fifo)
        begin
            if (next_slot_reg == IDX_W'(ENTRIES - 1))
            begin
                next_slot_next = '0;
            end
            else
            begin
                next_slot_next = next_slot_reg + IDX_W'(1);
            end
        end
        if (cmd.lookup)
        begin
            if (status.any_match)
            begin
                hit_total_next = hit_total_reg + TOTAL_W'(1);
            end
            else
            begin
                miss_total_next = miss_total_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot_reg  <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
        end
        else
        begin
            next_slot_reg  <= next_slot_next;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
        end
    end

    // Result transaction; fills report zero fields with the totals.
    always_comb
    begin
        out_next               = '0;
        out_next.hits_so_far   = hit_total_next;
        out_next.misses_so_far = miss_total_next;
        if (cmd.lookup && status.any_match)
        begin
            out_next.hit         = 1'b1;
            out_next.frame       = frame_reg[match_idx];
            out_next.frame_valid = ok_reg[match_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tlbfl_checker.sv
// -----------------------------------------------------------------------------
// TLB replacement port checker
// Checks transaction sequencing and result fields seen at the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tlb_fifo_lfu_replacement_assert.svh"

module tlbfl_checker
    import tlbfl_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      result_valid,
    input wire out_item_t result
);

    logic accept;

    assign accept = start && !busy;

    // An accepted transaction keeps the block busy in the next cycle.
    `TLBFL_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)

    // No result appears in the cycle right after an accept.
    `TLBFL_ASSERT_NEXT(a_accept_no_result, clk, rst_n, accept, !result_valid)

    // A result is only shown once the block has gone idle.
    `TLBFL_ASSERT_SAME(a_result_idle, clk, rst_n, result_valid, !busy)

    // A miss or fill carries no frame.
    `TLBFL_ASSERT_SAME(a_miss_zero, clk, rst_n, result_valid && !result.hit,
        (result.frame == '0) && !result.frame_valid)

endmodule

bind tlb_fifo_lfu_replacement tlbfl_checker u_tlbfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire
